// ===== rtl/doubly_linked_list_engine_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the doubly linked list engine.
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DOUBLY_LINKED_LIST_ENGINE_TOP_MACROS_SVH
`define DOUBLY_LINKED_LIST_ENGINE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DLLE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DLLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dlle_pkg.sv =====
// ----------------------------------------------------------------------------
// dlle_pkg
// Shared sizes, codes and value conversions of the linked list engine.
// ----------------------------------------------------------------------------
package dlle_pkg;

    localparam int NODES      = 64;
    localparam int VALUE_BITS = 32;
    localparam int IX_W       = $clog2(NODES);
    localparam int LINK_W     = IX_W + 1;
    localparam int PORT_W     = 32;

    // A link equal to the pool size means "no node".
    localparam logic [LINK_W-1:0] NONE_IX = LINK_W'(NODES);

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_NOT_IN_LIST = 2'd2
    } status_t;

    // Sign-extends or truncates a request value to the stored width.
    function automatic logic [VALUE_BITS-1:0] port_to_value(input logic [PORT_W-1:0] d);
        logic [63:0] w;
        w = 64'(signed'(d));
        return w[VALUE_BITS-1:0];
    endfunction

    // Stored values leave zero-extended and cut to the port width.
    function automatic logic [PORT_W-1:0] value_to_port(input logic [VALUE_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[PORT_W-1:0];
    endfunction

endpackage

// ===== rtl/dlle_ram.sv =====
// ----------------------------------------------------------------------------
// dlle_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dlle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/doubly_linked_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_top
// Doubly linked list over a fixed node pool, one command per request.
//
//   Channel | Handshake          | Fields
//   --------+--------------------+------------------------------------------
//   input   | in_valid/in_ready  | cmd, data_in, node_in
//   output  | out_valid/out_ready| status, node_out, data_out, prev_out,
//           |                    | next_out, head_out, tail_out, is_empty
//
// A request passes from IDLE through FETCH and DONE back to IDLE; an erase,
// and an append to a non-empty list, also pass through LINK, because the
// next-link memory has one write port and these need two writes to it.
// The result sits in an output register, so a new request is taken while it
// waits; only the final step of the next request stalls on out_ready.
// Reset clears the control registers and the membership bits at once; the
// value and link memories need no clearing.
// ----------------------------------------------------------------------------
`include "doubly_linked_list_engine_top_macros.svh"

module doubly_linked_list_engine_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       cmd,
    input  logic signed [dlle_pkg::PORT_W-1:0] data_in,
    input  logic [dlle_pkg::IX_W-1:0]        node_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic [dlle_pkg::IX_W-1:0]        node_out,
    output logic signed [dlle_pkg::PORT_W-1:0] data_out,
    output logic [dlle_pkg::LINK_W-1:0]      prev_out,
    output logic [dlle_pkg::LINK_W-1:0]      next_out,
    output logic [dlle_pkg::LINK_W-1:0]      head_out,
    output logic [dlle_pkg::LINK_W-1:0]      tail_out,
    output logic                             is_empty
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_LINK  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    dlle_pkg::cmd_t                 cmd_reg;
    logic [dlle_pkg::PORT_W-1:0]    data_reg;
    logic [dlle_pkg::IX_W-1:0]      node_reg;

    logic [dlle_pkg::LINK_W-1:0]    head_reg, head_next;
    logic [dlle_pkg::LINK_W-1:0]    tail_reg, tail_next;
    logic [dlle_pkg::LINK_W-1:0]    free_head_reg, free_head_next;
    logic [dlle_pkg::LINK_W-1:0]    fresh_reg, fresh_next;
    logic [dlle_pkg::NODES-1:0]     in_list_reg, in_list_next;

    dlle_pkg::status_t              res_status_reg, res_status_next;
    logic [dlle_pkg::IX_W-1:0]      res_node_reg, res_node_next;
    logic [dlle_pkg::PORT_W-1:0]    res_data_reg, res_data_next;
    logic [dlle_pkg::LINK_W-1:0]    res_prev_reg, res_prev_next;
    logic [dlle_pkg::LINK_W-1:0]    res_next_reg, res_next_next;
    logic [dlle_pkg::IX_W-1:0]      old_tail_reg, old_tail_next;

    logic                           out_valid_reg, out_valid_next;
    dlle_pkg::status_t              status_out_reg;
    logic [dlle_pkg::IX_W-1:0]      node_out_reg;
    logic [dlle_pkg::PORT_W-1:0]    data_out_reg;
    logic [dlle_pkg::LINK_W-1:0]    prev_out_reg, next_out_reg;
    logic [dlle_pkg::LINK_W-1:0]    head_out_reg, tail_out_reg;
    logic                           is_empty_reg;

    logic                           accept;
    logic                           load_out;
    logic [dlle_pkg::IX_W-1:0]      alloc_node;

    logic                           rd_en;
    logic [dlle_pkg::IX_W-1:0]      rd_addr;
    logic [dlle_pkg::VALUE_BITS-1:0] val_rdata;
    logic [dlle_pkg::LINK_W-1:0]    prev_rdata, next_rdata;

    logic                           val_we, prev_we, next_we;
    logic [dlle_pkg::IX_W-1:0]      val_waddr, prev_waddr, next_waddr;
    logic [dlle_pkg::VALUE_BITS-1:0] val_wdata;
    logic [dlle_pkg::LINK_W-1:0]    prev_wdata, next_wdata;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // An append reads the free-list successor; the other commands read the node.
    assign rd_en   = accept;
    assign rd_addr = (dlle_pkg::cmd_t'(cmd) == dlle_pkg::CMD_APPEND)
                   ? free_head_reg[dlle_pkg::IX_W-1:0] : node_in;

    dlle_ram #(.WIDTH(dlle_pkg::VALUE_BITS), .DEPTH(dlle_pkg::NODES)) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    dlle_ram #(.WIDTH(dlle_pkg::LINK_W), .DEPTH(dlle_pkg::NODES)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (prev_rdata)
    );

    dlle_ram #(.WIDTH(dlle_pkg::LINK_W), .DEPTH(dlle_pkg::NODES)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (next_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_head_next  = free_head_reg;
        fresh_next      = fresh_reg;
        in_list_next    = in_list_reg;
        res_status_next = res_status_reg;
        res_node_next   = res_node_reg;
        res_data_next   = res_data_reg;
        res_prev_next   = res_prev_reg;
        res_next_next   = res_next_reg;
        old_tail_next   = old_tail_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        alloc_node      = '0;

        val_we     = 1'b0;
        val_waddr  = '0;
        val_wdata  = '0;
        prev_we    = 1'b0;
        prev_waddr = '0;
        prev_wdata = '0;
        next_we    = 1'b0;
        next_waddr = '0;
        next_wdata = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_FETCH;
                end
            end

            S_FETCH:
            begin
                res_status_next = dlle_pkg::ST_OK;
                res_node_next   = '0;
                res_data_next   = '0;
                res_prev_next   = dlle_pkg::NONE_IX;
                res_next_next   = dlle_pkg::NONE_IX;
                state_next      = S_DONE;

                case (cmd_reg)
                    dlle_pkg::CMD_APPEND:
                    begin
                        if (free_head_reg < dlle_pkg::NONE_IX || fresh_reg < dlle_pkg::NONE_IX)
                        begin
                            // Recycled nodes go out before never-used ones.
                            if (free_head_reg < dlle_pkg::NONE_IX)
                            begin
                                alloc_node     = free_head_reg[dlle_pkg::IX_W-1:0];
                                free_head_next = (next_rdata > dlle_pkg::NONE_IX)
                                               ? dlle_pkg::NONE_IX : next_rdata;
                            end
                            else
                            begin
                                alloc_node = fresh_reg[dlle_pkg::IX_W-1:0];
                                fresh_next = fresh_reg + dlle_pkg::LINK_W'(1);
                            end
                            val_we     = 1'b1;
                            val_waddr  = alloc_node;
                            val_wdata  = dlle_pkg::port_to_value(data_reg);
                            prev_we    = 1'b1;
                            prev_waddr = alloc_node;
                            prev_wdata = tail_reg;
                            next_we    = 1'b1;
                            next_waddr = alloc_node;
                            next_wdata = dlle_pkg::NONE_IX;
                            in_list_next[alloc_node] = 1'b1;

                            res_node_next = alloc_node;
                            res_data_next = dlle_pkg::value_to_port(
                                                dlle_pkg::port_to_value(data_reg));
                            res_prev_next = tail_reg;
                            old_tail_next = tail_reg[dlle_pkg::IX_W-1:0];
                            tail_next     = {1'b0, alloc_node};
                            if (tail_reg < dlle_pkg::NONE_IX)
                            begin
                                state_next = S_LINK;
                            end
                            else
                            begin
                                head_next = {1'b0, alloc_node};
                            end
                        end
                        else
                        begin
                            res_status_next = dlle_pkg::ST_FULL;
                        end
                    end

                    dlle_pkg::CMD_ERASE,
                    dlle_pkg::CMD_READ:
                    begin
                        res_node_next = node_reg;
                        if (!in_list_reg[node_reg])
                        begin
                            res_status_next = dlle_pkg::ST_NOT_IN_LIST;
                        end
                        else
                        begin
                            res_data_next = dlle_pkg::value_to_port(val_rdata);
                            res_prev_next = prev_rdata;
                            res_next_next = next_rdata;
                            if (cmd_reg == dlle_pkg::CMD_ERASE)
                            begin
                                // Both neighbours relink in the same cycle: separate memories.
                                if (prev_rdata < dlle_pkg::NONE_IX)
                                begin
                                    next_we    = 1'b1;
                                    next_waddr = prev_rdata[dlle_pkg::IX_W-1:0];
                                    next_wdata = next_rdata;
                                end
                                else
                                begin
                                    head_next = next_rdata;
                                end
                                if (next_rdata < dlle_pkg::NONE_IX)
                                begin
                                    prev_we    = 1'b1;
                                    prev_waddr = next_rdata[dlle_pkg::IX_W-1:0];
                                    prev_wdata = prev_rdata;
                                end
                                else
                                begin
                                    tail_next = prev_rdata;
                                end
                                in_list_next[node_reg] = 1'b0;
                                state_next = S_LINK;
                            end
                        end
                    end

                    default:
                    begin
                        res_status_next = dlle_pkg::ST_OK;
                    end
                endcase
            end

            S_LINK:
            begin
                if (cmd_reg == dlle_pkg::CMD_APPEND)
                begin
                    next_we    = 1'b1;
                    next_waddr = old_tail_reg;
                    next_wdata = {1'b0, res_node_reg};
                end
                else
                begin
                    // The erased node heads the free list from now on.
                    next_we        = 1'b1;
                    next_waddr     = node_reg;
                    next_wdata     = free_head_reg;
                    prev_we        = 1'b1;
                    prev_waddr     = node_reg;
                    prev_wdata     = dlle_pkg::NONE_IX;
                    free_head_next = {1'b0, node_reg};
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= dlle_pkg::NONE_IX;
            tail_reg      <= dlle_pkg::NONE_IX;
            free_head_reg <= dlle_pkg::NONE_IX;
            fresh_reg     <= '0;
            in_list_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            in_list_reg   <= in_list_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= dlle_pkg::cmd_t'(cmd);
            data_reg <= data_in;
            node_reg <= node_in;
        end
        res_status_reg <= res_status_next;
        res_node_reg   <= res_node_next;
        res_data_reg   <= res_data_next;
        res_prev_reg   <= res_prev_next;
        res_next_reg   <= res_next_next;
        old_tail_reg   <= old_tail_next;
        if (load_out)
        begin
            status_out_reg <= res_status_reg;
            node_out_reg   <= res_node_reg;
            data_out_reg   <= res_data_reg;
            prev_out_reg   <= res_prev_reg;
            next_out_reg   <= res_next_reg;
            head_out_reg   <= head_reg;
            tail_out_reg   <= tail_reg;
            is_empty_reg   <= (head_reg == dlle_pkg::NONE_IX);
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_out_reg;
    assign node_out  = node_out_reg;
    assign data_out  = data_out_reg;
    assign prev_out  = prev_out_reg;
    assign next_out  = next_out_reg;
    assign head_out  = head_out_reg;
    assign tail_out  = tail_out_reg;
    assign is_empty  = is_empty_reg;

    // An empty list has neither head nor tail; a non-empty one has both.
    `DLLE_ASSERT_SAME(a_head_tail_agree, 1'b1,
        (head_reg == dlle_pkg::NONE_IX) == (tail_reg == dlle_pkg::NONE_IX),
        "head and tail disagree on whether the list is empty")

    `DLLE_ASSERT_SAME(a_fresh_bounded, 1'b1, fresh_reg <= dlle_pkg::NONE_IX,
        "never-used node count runs past the pool size")

    // A full report is only correct when the pool really is exhausted.
    `DLLE_ASSERT_SAME(a_full_is_real,
        load_out && res_status_reg == dlle_pkg::ST_FULL,
        fresh_reg == dlle_pkg::NONE_IX && free_head_reg == dlle_pkg::NONE_IX,
        "pool reported full while a node was still available")

    `DLLE_ASSERT_NEXT(a_erase_leaves_list,
        state_reg == S_FETCH && cmd_reg == dlle_pkg::CMD_ERASE && in_list_reg[node_reg],
        !in_list_reg[node_reg] && free_head_reg != {1'b0, node_reg} && state_reg == S_LINK,
        "erase did not take the node out of the list before relinking the pool")

endmodule
